// ===== src/gpupd_pkg.sv =====
// ----------------------------------------------------------------------------
// gpupd_pkg
// Shared types, constants and helpers for the gravity particle update pipeline.
// ----------------------------------------------------------------------------
package gpupd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 31;
    localparam int TOL_W     = 16;
    localparam int CFG_IDX_W = 8;

    localparam int SQ_ITER  = 32;
    localparam int DIV_ITER = FRAC_BITS + 1;
    localparam int DIV_W    = DATA_W + FRAC_BITS;
    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int UNIT_W   = FRAC_BITS + 2;
    localparam int PROD_W   = UNIT_W + DATA_W;

    localparam int ST_SQ0  = 3;
    localparam int ST_DV0  = ST_SQ0 + SQ_ITER;
    localparam int ST_U    = ST_DV0 + DIV_ITER;
    localparam int ST_MA   = ST_U + 1;
    localparam int ST_AC   = ST_MA + 1;
    localparam int ST_AD   = ST_AC + 1;
    localparam int ST_NV   = ST_AD + 1;
    localparam int ST_ND   = ST_NV + 1;
    localparam int ST_OUT  = ST_ND + 1;
    localparam int NUM_ST  = ST_OUT + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAV_X   = 8'd0,
        CFG_GRAV_Y   = 8'd1,
        CFG_GRAV_Z   = 8'd2,
        CFG_ZERO_TOL = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                          alive;
        logic                          uok;
        logic [DATA_W-1:0]             life;
        logic [DT_W-1:0]               dt;
        logic [2:0][DATA_W-1:0]        pos;
        logic [2:0][DATA_W-1:0]        vel;
        logic [DATA_W-1:0]             ra;
        logic [DATA_W-1:0]             ta;
        logic [2:0]                    neg;
        logic [2:0][DATA_W-1:0]        mag;
    } item_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== src/gravity_particle_update_top.sv =====
// throughput: one beat per cycle while the result is taken; the square root (32 stages) and the three
// dividers (one quotient bit per stage) are fully pipelined
// the whole pipeline holds when the result register is full and not taken
// reset clears all valid bits and sets gravity to zero and tolerance to one
// ----------------------------------------------------------------------------
// gravity_particle_update_top
// One Euler step of a gravity-mode particle: life, radial and tangential
// acceleration, gravity, velocity and position integration with saturation.
// ----------------------------------------------------------------------------
module gravity_particle_update_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gpupd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpupd_pkg::DATA_W-1:0]       cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gpupd_pkg::DT_W-1:0]         s_step_time,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_life_left,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_pos_x,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_pos_y,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_pos_z,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_vel_x,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_vel_y,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_vel_z,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_radial_accel,
    input  logic signed [gpupd_pkg::DATA_W-1:0] s_tangent_accel,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_alive,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_life,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_pos_x,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_pos_y,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_pos_z,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_vel_x,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_vel_y,
    output logic signed [gpupd_pkg::DATA_W-1:0] m_new_vel_z
);

    localparam int F   = gpupd_pkg::FRAC_BITS;
    localparam int DW  = gpupd_pkg::DATA_W;
    localparam int NS  = gpupd_pkg::NUM_ST;
    localparam int SQI = gpupd_pkg::SQ_ITER;
    localparam int DVI = gpupd_pkg::DIV_ITER;
    localparam int VW  = gpupd_pkg::DIV_W;
    localparam int QW  = gpupd_pkg::QUO_W;
    localparam int UW  = gpupd_pkg::UNIT_W;
    localparam int PW  = gpupd_pkg::PROD_W;

    localparam int ST_DV0 = gpupd_pkg::ST_DV0;
    localparam int ST_U   = gpupd_pkg::ST_U;
    localparam int ST_MA  = gpupd_pkg::ST_MA;
    localparam int ST_AD  = gpupd_pkg::ST_AD;
    localparam int ST_NV  = gpupd_pkg::ST_NV;
    localparam int ST_ND  = gpupd_pkg::ST_ND;
    localparam int ST_OUT = gpupd_pkg::ST_OUT;

    // config registers
    logic signed [DW-1:0]                  grav_reg [3];
    logic [gpupd_pkg::TOL_W-1:0]           tol_reg;

    logic [NS-1:0]                         vld_reg;
    gpupd_pkg::item_t                      itm_reg  [NS];
    gpupd_pkg::item_t                      itm_next;
    gpupd_pkg::item_t                      itm_s2;
    logic                                  en;

    logic [63:0]                           sq_reg   [3];
    logic [63:0]                           sum_next;
    logic [63:0]                           sum_reg;
    logic [63:0]                           rem_reg  [SQI];
    logic [63:0]                           res_reg  [SQI];
    logic [63:0]                           rem_next [SQI];
    logic [63:0]                           res_next [SQI];
    logic [DW-1:0]                         dlen_reg [DVI];
    logic [VW-1:0]                         dr_reg   [DVI][3];
    logic [QW-1:0]                         dq_reg   [DVI][3];
    logic [VW-1:0]                         dr_next  [DVI][3];
    logic [QW-1:0]                         dq_next  [DVI][3];
    logic signed [UW-1:0]                  u_reg    [3];
    logic signed [UW-1:0]                  u_next   [3];
    logic signed [UW-1:0]                  t_vec    [3];
    logic signed [PW-1:0]                  pr_reg   [3];
    logic signed [PW-1:0]                  pt_reg   [3];
    logic signed [DW-1:0]                  a_reg    [3];
    logic signed [63:0]                    ad_reg   [3];
    logic signed [DW-1:0]                  nv_reg   [3];
    logic signed [63:0]                    nd_reg   [3];
    logic signed [DW-1:0]                  np_reg   [3];
    logic                                  out_alive_reg;
    logic signed [DW-1:0]                  out_life_reg;

    assign en      = !vld_reg[NS-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg[0] <= '0;
            grav_reg[1] <= '0;
            grav_reg[2] <= '0;
            tol_reg     <= gpupd_pkg::TOL_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gpupd_pkg::CFG_GRAV_X:   grav_reg[0] <= cfg_wdata;
                gpupd_pkg::CFG_GRAV_Y:   grav_reg[1] <= cfg_wdata;
                gpupd_pkg::CFG_GRAV_Z:   grav_reg[2] <= cfg_wdata;
                gpupd_pkg::CFG_ZERO_TOL: tol_reg <= cfg_wdata[gpupd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // capture stage: life, magnitudes, near-origin test
    always_comb begin
        logic signed [63:0] lf;
        logic [2:0][DW-1:0] p;
        logic               near;
        logic signed [DW-1:0] ls;
        p    = {s_pos_z, s_pos_y, s_pos_x};
        lf   = 64'(s_life_left) - $signed({33'b0, s_step_time});
        ls   = gpupd_pkg::sat32(lf);
        near = 1'b1;
        itm_next.life  = ls;
        itm_next.alive = ls > 0;
        itm_next.dt    = s_step_time;
        itm_next.pos   = p;
        itm_next.vel   = {s_vel_z, s_vel_y, s_vel_x};
        itm_next.ra    = s_radial_accel;
        itm_next.ta    = s_tangent_accel;
        for (int c = 0; c < 3; c++) begin
            itm_next.neg[c] = p[c][DW-1];
            itm_next.mag[c] = p[c][DW-1] ? (~p[c] + DW'(1)) : p[c];
            if (itm_next.mag[c] >= DW'(tol_reg)) begin
                near = 1'b0;
            end
        end
        itm_next.uok = itm_next.alive && !near;
    end

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // zero sum of squares also clears the unit vector
    always_comb begin
        itm_s2     = itm_reg[1];
        itm_s2.uok = itm_reg[1].uok && (sum_next != 64'd0);
    end

    // square root, one result bit per stage
    always_comb begin
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] b;
        for (int k = 0; k < SQI; k++) begin
            r = (k == 0) ? sum_reg : rem_reg[(k == 0) ? 0 : k - 1];
            q = (k == 0) ? 64'd0   : res_reg[(k == 0) ? 0 : k - 1];
            b = 64'd1 << (2 * (SQI - 1 - k));
            if (r >= q + b) begin
                rem_next[k] = r - (q + b);
                res_next[k] = (q >> 1) + b;
            end else begin
                rem_next[k] = r;
                res_next[k] = q >> 1;
            end
        end
    end

    // restoring dividers, one quotient bit per stage
    always_comb begin
        logic [VW-1:0] r;
        logic [QW-1:0] q;
        logic [VW-1:0] d;
        logic [DW-1:0] l;
        for (int j = 0; j < DVI; j++) begin
            l = (j == 0) ? res_reg[SQI-1][DW-1:0] : dlen_reg[(j == 0) ? 0 : j - 1];
            d = VW'(l) << (DVI - 1 - j);
            for (int c = 0; c < 3; c++) begin
                if (j == 0) begin
                    r = VW'(itm_reg[ST_DV0-1].mag[c]) << F;
                    q = '0;
                end else begin
                    r = dr_reg[(j == 0) ? 0 : j - 1][c];
                    q = dq_reg[(j == 0) ? 0 : j - 1][c];
                end
                if (r >= d) begin
                    dr_next[j][c] = r - d;
                    dq_next[j][c] = q | (QW'(1) << (DVI - 1 - j));
                end else begin
                    dr_next[j][c] = r;
                    dq_next[j][c] = q;
                end
            end
        end
    end

    always_comb begin
        logic [QW-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = dq_reg[DVI-1][c];
            if (!itm_reg[ST_U-1].uok) begin
                u_next[c] = '0;
            end else if (itm_reg[ST_U-1].neg[c]) begin
                u_next[c] = -$signed(UW'(q));
            end else begin
                u_next[c] = $signed(UW'(q));
            end
        end
        t_vec[0] = -u_reg[1];
        t_vec[1] = u_reg[0];
        t_vec[2] = u_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            itm_reg[0] <= itm_next;
            for (int k = 1; k < NS; k++) begin
                if (k != 2) begin
                    itm_reg[k] <= itm_reg[k-1];
                end
            end
            itm_reg[2] <= itm_s2;
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= 64'(itm_reg[0].mag[c]) * 64'(itm_reg[0].mag[c]);
            end
            sum_reg <= sum_next;
            for (int k = 0; k < SQI; k++) begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
            dlen_reg[0] <= res_reg[SQI-1][DW-1:0];
            for (int j = 1; j < DVI; j++) begin
                dlen_reg[j] <= dlen_reg[j-1];
            end
            for (int j = 0; j < DVI; j++) begin
                for (int c = 0; c < 3; c++) begin
                    dr_reg[j][c] <= dr_next[j][c];
                    dq_reg[j][c] <= dq_next[j][c];
                end
            end
            for (int c = 0; c < 3; c++) begin
                u_reg[c]  <= u_next[c];
                pr_reg[c] <= PW'(u_reg[c]) * PW'($signed(itm_reg[ST_MA-1].ra));
                pt_reg[c] <= PW'(t_vec[c]) * PW'($signed(itm_reg[ST_MA-1].ta));
                a_reg[c]  <= gpupd_pkg::sat32((64'(pr_reg[c]) >>> F) + (64'(pt_reg[c]) >>> F)
                                              + 64'(grav_reg[c]));
                ad_reg[c] <= 64'(a_reg[c]) * $signed({33'b0, itm_reg[ST_AD-1].dt});
                nv_reg[c] <= gpupd_pkg::sat32(64'($signed(itm_reg[ST_NV-1].vel[c]))
                                              + (ad_reg[c] >>> F));
                nd_reg[c] <= 64'(nv_reg[c]) * $signed({33'b0, itm_reg[ST_ND-1].dt});
                np_reg[c] <= itm_reg[ST_OUT-1].alive ?
                             gpupd_pkg::sat32(64'($signed(itm_reg[ST_OUT-1].pos[c]))
                                              + (nd_reg[c] >>> F)) : '0;
            end
            out_alive_reg <= itm_reg[ST_OUT-1].alive;
            out_life_reg  <= itm_reg[ST_OUT-1].life;
        end
    end

    // velocity is held in nv_hold_reg beside nd_reg, so the output copy is taken from the nd stage
    logic signed [DW-1:0] nv_hold_reg [3];
    logic signed [DW-1:0] vout_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                vout_reg[c] <= itm_reg[ST_OUT-1].alive ? nv_hold_reg[c] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                nv_hold_reg[c] <= nv_reg[c];
            end
        end
    end

    assign m_valid     = vld_reg[NS-1];
    assign m_alive     = out_alive_reg;
    assign m_new_life  = out_life_reg;
    assign m_new_pos_x = np_reg[0];
    assign m_new_pos_y = np_reg[1];
    assign m_new_pos_z = np_reg[2];
    assign m_new_vel_x = vout_reg[0];
    assign m_new_vel_y = vout_reg[1];
    assign m_new_vel_z = vout_reg[2];

    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_alive |-> m_new_pos_x == 0 && m_new_pos_y == 0 && m_new_pos_z == 0
                                && m_new_vel_x == 0 && m_new_vel_y == 0 && m_new_vel_z == 0)
        else $error("expired particle with nonzero motion");

    a_alive_life: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alive |-> m_new_life > 0)
        else $error("live particle with nonpositive life");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_DV0] && itm_reg[ST_DV0].uok |-> dlen_reg[0] != '0)
        else $error("zero length on a live unit vector");

    a_unit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_U] && !itm_reg[ST_U].uok |-> u_reg[0] == 0 && u_reg[1] == 0 && u_reg[2] == 0)
        else $error("unit vector not cleared");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during stall");

endmodule
